// ===== sv/aabb_por_pkg.sv =====
package aabb_por_pkg;

   localparam int MAX_ROUNDS = 4096;
   localparam int RND_W      = $clog2(MAX_ROUNDS + 1);
   localparam int POS_W      = 32;
   localparam int HALF_W     = 31;
   localparam int STEP_W     = 31;
   localparam int SC_W       = POS_W + 1;
   localparam int HS_W       = HALF_W + 1;
   localparam int DIFF_W     = SC_W + 1;
   // push distance can reach (MAX_ROUNDS + 1) * step after the last round update
   localparam int D_W        = RND_W + STEP_W;
   localparam int SUM_W      = D_W + 2;
   localparam int PC_W       = 5;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6554);

   localparam logic [1:0] CSR_OFFSET_X  = 2'd0;
   localparam logic [1:0] CSR_OFFSET_Y  = 2'd1;
   localparam logic [1:0] CSR_OFFSET_Z  = 2'd2;
   localparam logic [1:0] CSR_PUSH_STEP = 2'd3;

   // microprogram entry points
   localparam logic [PC_W-1:0] UC_WAIT  = PC_W'(0);
   localparam logic [PC_W-1:0] UC_INIT  = PC_W'(1);
   localparam logic [PC_W-1:0] UC_ROUND = PC_W'(7);
   localparam logic [PC_W-1:0] UC_NEXT  = PC_W'(25);
   localparam logic [PC_W-1:0] UC_UNRES = PC_W'(26);
   localparam logic [PC_W-1:0] UC_FREE  = PC_W'(27);
   localparam logic [PC_W-1:0] UC_FOUND = PC_W'(28);

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIFF_MC,
      OP_CAND,
      OP_DIFF_CAND,
      OP_NEXT_ROUND,
      OP_EMIT_FREE,
      OP_EMIT_FOUND,
      OP_EMIT_UNRES
   } op_type;

   typedef enum logic [2:0] {
      C_STEP,
      C_NO_REQ,
      C_APART,
      C_MORE,
      C_EMIT,
      C_GOTO
   } cond_type;

   typedef struct packed {
      op_type          op;
      axis_type        ax;
      logic            neg;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic     idle;
      op_type   op;
      axis_type ax;
      logic     neg;
   } ctl_type;

   typedef struct packed {
      logic apart;
      logic more_rounds;
      logic rsp_busy;
   } stat_type;

   function automatic uword_type uw(input op_type op, input axis_type ax, input logic neg,
                                    input cond_type cond, input logic [PC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.ax     = ax;
      w.neg    = neg;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Control store. Each candidate takes three steps: form the moved coordinate,
   // subtract it from the static centre, test that axis for separation.
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         UC_WAIT:              w = uw(OP_NOP,        AXIS_X, 1'b0, C_NO_REQ, UC_WAIT);
         UC_INIT:              w = uw(OP_DIFF_MC,    AXIS_X, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_INIT + 1):   w = uw(OP_NOP,        AXIS_X, 1'b0, C_APART,  UC_FREE);
         PC_W'(UC_INIT + 2):   w = uw(OP_DIFF_MC,    AXIS_Y, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_INIT + 3):   w = uw(OP_NOP,        AXIS_Y, 1'b0, C_APART,  UC_FREE);
         PC_W'(UC_INIT + 4):   w = uw(OP_DIFF_MC,    AXIS_Z, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_INIT + 5):   w = uw(OP_NOP,        AXIS_Z, 1'b0, C_APART,  UC_FREE);
         UC_ROUND:             w = uw(OP_CAND,       AXIS_X, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 1):  w = uw(OP_DIFF_CAND,  AXIS_X, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 2):  w = uw(OP_NOP,        AXIS_X, 1'b0, C_APART,  UC_FOUND);
         PC_W'(UC_ROUND + 3):  w = uw(OP_CAND,       AXIS_X, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 4):  w = uw(OP_DIFF_CAND,  AXIS_X, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 5):  w = uw(OP_NOP,        AXIS_X, 1'b1, C_APART,  UC_FOUND);
         PC_W'(UC_ROUND + 6):  w = uw(OP_CAND,       AXIS_Z, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 7):  w = uw(OP_DIFF_CAND,  AXIS_Z, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 8):  w = uw(OP_NOP,        AXIS_Z, 1'b0, C_APART,  UC_FOUND);
         PC_W'(UC_ROUND + 9):  w = uw(OP_CAND,       AXIS_Z, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 10): w = uw(OP_DIFF_CAND,  AXIS_Z, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 11): w = uw(OP_NOP,        AXIS_Z, 1'b1, C_APART,  UC_FOUND);
         PC_W'(UC_ROUND + 12): w = uw(OP_CAND,       AXIS_Y, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 13): w = uw(OP_DIFF_CAND,  AXIS_Y, 1'b0, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 14): w = uw(OP_NOP,        AXIS_Y, 1'b0, C_APART,  UC_FOUND);
         PC_W'(UC_ROUND + 15): w = uw(OP_CAND,       AXIS_Y, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 16): w = uw(OP_DIFF_CAND,  AXIS_Y, 1'b1, C_STEP,   UC_WAIT);
         PC_W'(UC_ROUND + 17): w = uw(OP_NOP,        AXIS_Y, 1'b1, C_APART,  UC_FOUND);
         UC_NEXT:              w = uw(OP_NEXT_ROUND, AXIS_X, 1'b0, C_MORE,   UC_ROUND);
         UC_UNRES:             w = uw(OP_EMIT_UNRES, AXIS_X, 1'b0, C_EMIT,   UC_WAIT);
         UC_FREE:              w = uw(OP_EMIT_FREE,  AXIS_X, 1'b0, C_EMIT,   UC_WAIT);
         UC_FOUND:             w = uw(OP_EMIT_FOUND, AXIS_X, 1'b0, C_EMIT,   UC_WAIT);
         default:              w = uw(OP_NOP,        AXIS_X, 1'b0, C_GOTO,   UC_WAIT);
      endcase
      return w;
   endfunction

endpackage

// ===== sv/aabb_por_seq.sv =====
module aabb_por_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  aabb_por_pkg::stat_type stat,
   output aabb_por_pkg::ctl_type  ctl
);

   logic [aabb_por_pkg::PC_W-1:0] pc_ff;
   logic [aabb_por_pkg::PC_W-1:0] pc_in;
   aabb_por_pkg::uword_type       word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= aabb_por_pkg::UC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      word = aabb_por_pkg::ucode(pc_ff);
      unique case (word.cond)
         aabb_por_pkg::C_STEP:   pc_in = pc_ff + 1'b1;
         aabb_por_pkg::C_NO_REQ: pc_in = req_valid ? pc_ff + 1'b1 : word.target;
         aabb_por_pkg::C_APART:  pc_in = stat.apart ? word.target : pc_ff + 1'b1;
         aabb_por_pkg::C_MORE:   pc_in = stat.more_rounds ? word.target : pc_ff + 1'b1;
         aabb_por_pkg::C_EMIT:   pc_in = stat.rsp_busy ? pc_ff : word.target;
         aabb_por_pkg::C_GOTO:   pc_in = word.target;
         default:                pc_in = aabb_por_pkg::UC_WAIT;
      endcase
      ctl.idle = (pc_ff == aabb_por_pkg::UC_WAIT);
      ctl.op   = word.op;
      ctl.ax   = word.ax;
      ctl.neg  = word.neg;
   end

endmodule

// ===== sv/aabb_por_dp.sv =====
module aabb_por_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  aabb_por_pkg::ctl_type  ctl,
   output aabb_por_pkg::stat_type stat,
   input  logic                   req_valid,
   input  logic signed [31:0]     req_static_x,
   input  logic signed [31:0]     req_static_y,
   input  logic signed [31:0]     req_static_z,
   input  logic [30:0]            req_static_half_x,
   input  logic [30:0]            req_static_half_y,
   input  logic [30:0]            req_static_half_z,
   input  logic signed [31:0]     req_moving_x,
   input  logic signed [31:0]     req_moving_y,
   input  logic signed [31:0]     req_moving_z,
   input  logic [30:0]            req_moving_half_x,
   input  logic [30:0]            req_moving_half_y,
   input  logic [30:0]            req_moving_half_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_out_x,
   output logic signed [31:0]     rsp_out_y,
   output logic signed [31:0]     rsp_out_z,
   output logic                   rsp_was_overlapping,
   output logic                   rsp_unresolved,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   logic signed [aabb_por_pkg::POS_W-1:0]  off_ff [3];
   logic [aabb_por_pkg::STEP_W-1:0]        step_ff;

   logic signed [aabb_por_pkg::SC_W-1:0]   sc_ff [3];
   logic [aabb_por_pkg::HS_W-1:0]          hs_ff [3];
   logic signed [aabb_por_pkg::POS_W-1:0]  mc_ff [3];
   logic [aabb_por_pkg::D_W-1:0]           d_ff;
   logic [aabb_por_pkg::RND_W-1:0]         round_ff;
   logic signed [aabb_por_pkg::POS_W-1:0]  cand_ff;
   aabb_por_pkg::axis_type                 cand_ax_ff;
   logic signed [aabb_por_pkg::DIFF_W-1:0] diff_ff;
   aabb_por_pkg::axis_type                 diff_ax_ff;

   logic                                   rsp_valid_ff;
   logic signed [aabb_por_pkg::POS_W-1:0]  rsp_pos_ff [3];
   logic                                   rsp_ovl_ff;
   logic                                   rsp_unres_ff;

   logic signed [aabb_por_pkg::POS_W-1:0]  in_static [3];
   logic [aabb_por_pkg::HALF_W-1:0]        in_shalf [3];
   logic signed [aabb_por_pkg::POS_W-1:0]  in_moving [3];
   logic [aabb_por_pkg::HALF_W-1:0]        in_mhalf [3];

   logic                                   load;
   logic                                   emit;
   logic signed [aabb_por_pkg::SUM_W-1:0]  sum_in;
   logic signed [aabb_por_pkg::POS_W-1:0]  cand_in;
   logic                                   sum_ovf;
   logic signed [aabb_por_pkg::DIFF_W-1:0] hs_ext;
   logic signed [aabb_por_pkg::POS_W-1:0]  found_pos [3];

   assign in_static[0] = req_static_x;
   assign in_static[1] = req_static_y;
   assign in_static[2] = req_static_z;
   assign in_shalf[0]  = req_static_half_x;
   assign in_shalf[1]  = req_static_half_y;
   assign in_shalf[2]  = req_static_half_z;
   assign in_moving[0] = req_moving_x;
   assign in_moving[1] = req_moving_y;
   assign in_moving[2] = req_moving_z;
   assign in_mhalf[0]  = req_moving_half_x;
   assign in_mhalf[1]  = req_moving_half_y;
   assign in_mhalf[2]  = req_moving_half_z;

   assign load = ctl.idle & req_valid;
   assign stat.rsp_busy = rsp_valid_ff & rsp_stall;
   assign emit = ((ctl.op == aabb_por_pkg::OP_EMIT_FREE) ||
                  (ctl.op == aabb_por_pkg::OP_EMIT_FOUND) ||
                  (ctl.op == aabb_por_pkg::OP_EMIT_UNRES)) && !stat.rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
         step_ff   <= aabb_por_pkg::STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            aabb_por_pkg::CSR_OFFSET_X:  off_ff[0] <= csr_data;
            aabb_por_pkg::CSR_OFFSET_Y:  off_ff[1] <= csr_data;
            aabb_por_pkg::CSR_OFFSET_Z:  off_ff[2] <= csr_data;
            aabb_por_pkg::CSR_PUSH_STEP: step_ff   <= csr_data[aabb_por_pkg::STEP_W-1:0];
         endcase
      end
   end

   // centre +/- distance, clamped to the signed 32-bit range
   always_comb begin
      if (ctl.neg) begin
         sum_in = aabb_por_pkg::SUM_W'(mc_ff[ctl.ax]) - $signed({2'b00, d_ff});
      end else begin
         sum_in = aabb_por_pkg::SUM_W'(mc_ff[ctl.ax]) + $signed({2'b00, d_ff});
      end
      sum_ovf = !((&sum_in[aabb_por_pkg::SUM_W-1:aabb_por_pkg::POS_W-1]) ||
                  (~|sum_in[aabb_por_pkg::SUM_W-1:aabb_por_pkg::POS_W-1]));
      if (sum_ovf) begin
         cand_in = sum_in[aabb_por_pkg::SUM_W-1] ? {1'b1, {(aabb_por_pkg::POS_W-1){1'b0}}}
                                                 : {1'b0, {(aabb_por_pkg::POS_W-1){1'b1}}};
      end else begin
         cand_in = sum_in[aabb_por_pkg::POS_W-1:0];
      end
   end

   // separated on an axis when |static - moving| exceeds the half-extent sum
   assign hs_ext = $signed({2'b00, hs_ff[diff_ax_ff]});
   assign stat.apart = (diff_ff > hs_ext) || (diff_ff < -hs_ext);
   assign stat.more_rounds = (round_ff != aabb_por_pkg::RND_W'(aabb_por_pkg::MAX_ROUNDS));

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 3; k++) begin
            sc_ff[k] <= aabb_por_pkg::SC_W'(in_static[k]) + aabb_por_pkg::SC_W'(off_ff[k]);
            hs_ff[k] <= aabb_por_pkg::HS_W'(in_shalf[k]) + aabb_por_pkg::HS_W'(in_mhalf[k]);
            mc_ff[k] <= in_moving[k];
         end
         d_ff     <= aabb_por_pkg::D_W'(step_ff);
         round_ff <= aabb_por_pkg::RND_W'(1);
      end
      unique case (ctl.op)
         aabb_por_pkg::OP_DIFF_MC: begin
            diff_ff    <= aabb_por_pkg::DIFF_W'(sc_ff[ctl.ax]) -
                          aabb_por_pkg::DIFF_W'(mc_ff[ctl.ax]);
            diff_ax_ff <= ctl.ax;
         end
         aabb_por_pkg::OP_CAND: begin
            cand_ff    <= cand_in;
            cand_ax_ff <= ctl.ax;
         end
         aabb_por_pkg::OP_DIFF_CAND: begin
            diff_ff    <= aabb_por_pkg::DIFF_W'(sc_ff[cand_ax_ff]) -
                          aabb_por_pkg::DIFF_W'(cand_ff);
            diff_ax_ff <= cand_ax_ff;
         end
         aabb_por_pkg::OP_NEXT_ROUND: begin
            d_ff     <= d_ff + aabb_por_pkg::D_W'(step_ff);
            round_ff <= round_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign found_pos[0] = (cand_ax_ff == aabb_por_pkg::AXIS_X) ? cand_ff : mc_ff[0];
   assign found_pos[1] = (cand_ax_ff == aabb_por_pkg::AXIS_Y) ? cand_ff : mc_ff[1];
   assign found_pos[2] = (cand_ax_ff == aabb_por_pkg::AXIS_Z) ? cand_ff : mc_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (ctl.op == aabb_por_pkg::OP_EMIT_FOUND) begin
            for (int k = 0; k < 3; k++) begin
               rsp_pos_ff[k] <= found_pos[k];
            end
         end else begin
            for (int k = 0; k < 3; k++) begin
               rsp_pos_ff[k] <= mc_ff[k];
            end
         end
         rsp_ovl_ff   <= (ctl.op != aabb_por_pkg::OP_EMIT_FREE);
         rsp_unres_ff <= (ctl.op == aabb_por_pkg::OP_EMIT_UNRES);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = rsp_pos_ff[0];
   assign rsp_out_y           = rsp_pos_ff[1];
   assign rsp_out_z           = rsp_pos_ff[2];
   assign rsp_was_overlapping = rsp_ovl_ff;
   assign rsp_unresolved      = rsp_unres_ff;

endmodule

// ===== sv/aabb_push_out_resolver.sv =====
// channel | direction | handshake                   | word
// req     | in        | req_valid / req_stall (out) | static box, moving box
// rsp     | out       | rsp_valid / rsp_stall (in)  | resolved centre, flags
// csr     | in        | csr_write, no wait          | csr_index, csr_data
//
// One word at a time, paced by the microprogram through a single subtract/compare unit.
// No initial overlap: the result follows the per-axis separation tests. Otherwise candidates
// t (1..6) of rounds r = 1..MAX_ROUNDS are tried until one is free, else the result is unresolved.
// Synchronous reset returns the sequencer to its wait step and loads the csr defaults.
// A new word is taken while the last result still waits; rsp_stall only holds the
// sequencer at its emit step.
module aabb_push_out_resolver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_static_x,
   input  logic signed [31:0] req_static_y,
   input  logic signed [31:0] req_static_z,
   input  logic [30:0]        req_static_half_x,
   input  logic [30:0]        req_static_half_y,
   input  logic [30:0]        req_static_half_z,
   input  logic signed [31:0] req_moving_x,
   input  logic signed [31:0] req_moving_y,
   input  logic signed [31:0] req_moving_z,
   input  logic [30:0]        req_moving_half_x,
   input  logic [30:0]        req_moving_half_y,
   input  logic [30:0]        req_moving_half_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_was_overlapping,
   output logic               rsp_unresolved,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   aabb_por_pkg::ctl_type  ctl;
   aabb_por_pkg::stat_type stat;

   assign req_stall = !ctl.idle;

   aabb_por_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctl       (ctl)
   );

   aabb_por_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_valid           (req_valid),
      .req_static_x        (req_static_x),
      .req_static_y        (req_static_y),
      .req_static_z        (req_static_z),
      .req_static_half_x   (req_static_half_x),
      .req_static_half_y   (req_static_half_y),
      .req_static_half_z   (req_static_half_z),
      .req_moving_x        (req_moving_x),
      .req_moving_y        (req_moving_y),
      .req_moving_z        (req_moving_z),
      .req_moving_half_x   (req_moving_half_x),
      .req_moving_half_y   (req_moving_half_y),
      .req_moving_half_z   (req_moving_half_z),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_was_overlapping (rsp_was_overlapping),
      .rsp_unresolved      (rsp_unresolved),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

// ===== sv/aabb_por_chk.sv =====
module aabb_por_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_was_overlapping,
   input logic rsp_unresolved
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_unres_implies_ovl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_unresolved || rsp_was_overlapping))
      else $error("unresolved result without initial overlap");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind aabb_push_out_resolver aabb_por_chk u_chk (.*);

// ===== test/aabb_push_checker.sv =====
`timescale 1ns / 1ps

// Watches all three ports. Predicts each result word from the accepted request word and the
// csr values, and compares it field by field with what comes out.
module aabb_push_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_static_x,
   input  logic signed [31:0] req_static_y,
   input  logic signed [31:0] req_static_z,
   input  logic [30:0]        req_static_half_x,
   input  logic [30:0]        req_static_half_y,
   input  logic [30:0]        req_static_half_z,
   input  logic signed [31:0] req_moving_x,
   input  logic signed [31:0] req_moving_y,
   input  logic signed [31:0] req_moving_z,
   input  logic [30:0]        req_moving_half_x,
   input  logic [30:0]        req_moving_half_y,
   input  logic [30:0]        req_moving_half_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_out_x,
   input  logic signed [31:0] rsp_out_y,
   input  logic signed [31:0] rsp_out_z,
   input  logic               rsp_was_overlapping,
   input  logic               rsp_unresolved,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 results_seen,
   output int                 overlaps_seen,
   output int                 unresolved_seen,
   output int                 expect_depth
);

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               was_overlapping;
      logic               unresolved;
   } push_word_type;

   logic signed [31:0]              off_x;
   logic signed [31:0]              off_y;
   logic signed [31:0]              off_z;
   logic [aabb_por_pkg::STEP_W-1:0] push_step;
   push_word_type                   expected_q[$];

   function automatic longint clamp32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF))
         return longint'(32'sh7FFF_FFFF);
      if (v < longint'(32'sh8000_0000))
         return longint'(32'sh8000_0000);
      return v;
   endfunction

   // Intervals are apart only when one far edge is strictly past the other; touching overlaps.
   function automatic bit axis_apart(input longint a, input longint ah,
                                     input longint b, input longint bh);
      if (a > b)
         return (a - ah) > (b + bh);
      return (b - bh) > (a + ah);
   endfunction

   function automatic bit boxes_hit(input longint sx, input longint sy, input longint sz,
                                    input longint shx, input longint shy, input longint shz,
                                    input longint mx, input longint my, input longint mz,
                                    input longint mhx, input longint mhy, input longint mhz);
      return !(axis_apart(sx, shx, mx, mhx) || axis_apart(sy, shy, my, mhy) ||
               axis_apart(sz, shz, mz, mhz));
   endfunction

   function automatic push_word_type resolve_push(
         input longint scx, input longint scy, input longint scz,
         input longint shx, input longint shy, input longint shz,
         input longint mx, input longint my, input longint mz,
         input longint mhx, input longint mhy, input longint mhz);
      push_word_type res;
      longint        d;
      longint        cx;
      longint        cy;
      longint        cz;
      bit            found;
      res.out_x           = mx[31:0];
      res.out_y           = my[31:0];
      res.out_z           = mz[31:0];
      res.was_overlapping = boxes_hit(scx, scy, scz, shx, shy, shz, mx, my, mz, mhx, mhy, mhz);
      res.unresolved      = 1'b0;
      if (res.was_overlapping) begin
         found = 1'b0;
         for (longint r = 1; r <= aabb_por_pkg::MAX_ROUNDS && !found; r++) begin
            d = r * longint'(push_step);
            // candidate order within a round: +x -x +z -z +y -y
            for (int t = 0; t < 6 && !found; t++) begin
               cx = mx;
               cy = my;
               cz = mz;
               unique case (t)
                  0: cx = clamp32(mx + d);
                  1: cx = clamp32(mx - d);
                  2: cz = clamp32(mz + d);
                  3: cz = clamp32(mz - d);
                  4: cy = clamp32(my + d);
                  default: cy = clamp32(my - d);
               endcase
               if (!boxes_hit(scx, scy, scz, shx, shy, shz, cx, cy, cz, mhx, mhy, mhz)) begin
                  found     = 1'b1;
                  res.out_x = cx[31:0];
                  res.out_y = cy[31:0];
                  res.out_z = cz[31:0];
               end
            end
         end
         res.unresolved = !found;
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      push_word_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         off_x           <= '0;
         off_y           <= '0;
         off_z           <= '0;
         push_step       <= aabb_por_pkg::STEP_RESET;
         expected_q.delete();
         fail_count      <= 0;
         results_seen    <= 0;
         overlaps_seen   <= 0;
         unresolved_seen <= 0;
         expect_depth    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
               $error("result word arrived with nothing expected");
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (want.was_overlapping)
                  overlaps_seen <= overlaps_seen + 1;
               if (want.unresolved)
                  unresolved_seen <= unresolved_seen + 1;
               if (rsp_out_x !== want.out_x) begin
                  $error("out_x: expected %0d, got %0d", want.out_x, rsp_out_x);
                  errs++;
               end
               if (rsp_out_y !== want.out_y) begin
                  $error("out_y: expected %0d, got %0d", want.out_y, rsp_out_y);
                  errs++;
               end
               if (rsp_out_z !== want.out_z) begin
                  $error("out_z: expected %0d, got %0d", want.out_z, rsp_out_z);
                  errs++;
               end
               if (rsp_was_overlapping !== want.was_overlapping) begin
                  $error("was_overlapping: expected %0d, got %0d",
                         want.was_overlapping, rsp_was_overlapping);
                  errs++;
               end
               if (rsp_unresolved !== want.unresolved) begin
                  $error("unresolved: expected %0d, got %0d", want.unresolved, rsp_unresolved);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(resolve_push(
               longint'(req_static_x) + longint'(off_x),
               longint'(req_static_y) + longint'(off_y),
               longint'(req_static_z) + longint'(off_z),
               longint'(req_static_half_x), longint'(req_static_half_y),
               longint'(req_static_half_z),
               longint'(req_moving_x), longint'(req_moving_y), longint'(req_moving_z),
               longint'(req_moving_half_x), longint'(req_moving_half_y),
               longint'(req_moving_half_z)));
         if (csr_write) begin
            unique case (csr_index)
               aabb_por_pkg::CSR_OFFSET_X:  off_x <= csr_data;
               aabb_por_pkg::CSR_OFFSET_Y:  off_y <= csr_data;
               aabb_por_pkg::CSR_OFFSET_Z:  off_z <= csr_data;
               aabb_por_pkg::CSR_PUSH_STEP: push_step <= csr_data[aabb_por_pkg::STEP_W-1:0];
            endcase
         end
         fail_count   <= fail_count + errs;
         expect_depth <= expected_q.size();
      end
   end

endmodule

// ===== test/tb_aabb_push_out_resolver.sv =====
`timescale 1ns / 1ps

module tb_aabb_push_out_resolver;

   localparam logic signed [31:0] ONE      = 32'sh0001_0000;
   localparam logic signed [31:0] POS_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN  = 32'sh8000_0000;
   localparam logic [30:0]        HALF_ONE = 31'h0001_0000;
   localparam logic [30:0]        HALF_MAX = 31'h7FFF_FFFF;
   // an unresolved word runs through all MAX_ROUNDS rounds; allow several of those
   localparam int STALL_LIMIT = 320_000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] sz;
      logic [30:0]        shx;
      logic [30:0]        shy;
      logic [30:0]        shz;
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic signed [31:0] mz;
      logic [30:0]        mhx;
      logic [30:0]        mhy;
      logic [30:0]        mhz;
   } box_pair_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_static_x;
   logic signed [31:0] req_static_y;
   logic signed [31:0] req_static_z;
   logic [30:0]        req_static_half_x;
   logic [30:0]        req_static_half_y;
   logic [30:0]        req_static_half_z;
   logic signed [31:0] req_moving_x;
   logic signed [31:0] req_moving_y;
   logic signed [31:0] req_moving_z;
   logic [30:0]        req_moving_half_x;
   logic [30:0]        req_moving_half_y;
   logic [30:0]        req_moving_half_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_was_overlapping;
   logic               rsp_unresolved;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   int fail_count;
   int results_seen;
   int overlaps_seen;
   int unresolved_seen;
   int expect_depth;

   logic signed [31:0] cur_ox;
   logic signed [31:0] cur_oy;
   logic signed [31:0] cur_oz;
   int                 items_sent;
   int                 settings;
   int                 idle_cycles;
   int                 hold_left;
   bit                 calm;
   bit                 hold_request;
   logic [30:0]        mid_step;

   aabb_push_out_resolver dut (.*);

   aabb_push_checker result_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic box_pair_type pair_of(
         input logic signed [31:0] sx, input logic signed [31:0] sy, input logic signed [31:0] sz,
         input logic [30:0] shx, input logic [30:0] shy, input logic [30:0] shz,
         input logic signed [31:0] mx, input logic signed [31:0] my, input logic signed [31:0] mz,
         input logic [30:0] mhx, input logic [30:0] mhy, input logic [30:0] mhz);
      box_pair_type p;
      p = '{sx, sy, sz, shx, shy, shz, mx, my, mz, mhx, mhy, mhz};
      return p;
   endfunction

   function automatic longint rand_upto(input longint lim);
      longint unsigned r;
      r = {$urandom, $urandom};
      return longint'(r % longint'(lim + 1));
   endfunction

   function automatic logic signed [31:0] small_offset();
      return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
   endfunction

   // moving coordinate around static centre sc: inside the overlap band, or on its rim or one lsb past it
   function automatic logic signed [31:0] near(input longint sc, input longint lim,
                                               input bit on_rim);
      longint dlt;
      longint v;
      dlt = on_rim ? lim + $urandom_range(0, 1) : rand_upto(lim);
      if ($urandom_range(0, 1))
         dlt = -dlt;
      v = sc + dlt;
      if (v > POS_MAX)
         return POS_MAX;
      if (v < POS_MIN)
         return POS_MIN;
      return v[31:0];
   endfunction

   function automatic box_pair_type make_pair(input longint hmax);
      box_pair_type p;
      int           kind;
      int           rim_ax;
      kind   = $urandom_range(0, 99);
      rim_ax = (kind >= 55 && kind < 70) ? $urandom_range(0, 2) : 3;
      p.sx   = $urandom;
      p.sy   = $urandom;
      p.sz   = $urandom;
      p.shx  = 31'(rand_upto(hmax));
      p.shy  = 31'(rand_upto(hmax));
      p.shz  = 31'(rand_upto(hmax));
      p.mhx  = 31'(rand_upto(hmax));
      p.mhy  = 31'(rand_upto(hmax));
      p.mhz  = 31'(rand_upto(hmax));
      if (kind < 70) begin
         p.mx = near(longint'(p.sx) + longint'(cur_ox), longint'(p.shx) + longint'(p.mhx),
                     rim_ax == 0);
         p.my = near(longint'(p.sy) + longint'(cur_oy), longint'(p.shy) + longint'(p.mhy),
                     rim_ax == 1);
         p.mz = near(longint'(p.sz) + longint'(cur_oz), longint'(p.shz) + longint'(p.mhz),
                     rim_ax == 2);
      end else begin
         p.mx = $urandom;
         p.my = $urandom;
         p.mz = $urandom;
      end
      return p;
   endfunction

   task automatic send_pair(input box_pair_type p);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_static_x      <= p.sx;
      req_static_y      <= p.sy;
      req_static_z      <= p.sz;
      req_static_half_x <= p.shx;
      req_static_half_y <= p.shy;
      req_static_half_z <= p.shz;
      req_moving_x      <= p.mx;
      req_moving_y      <= p.my;
      req_moving_z      <= p.mz;
      req_moving_half_x <= p.mhx;
      req_moving_half_y <= p.mhy;
      req_moving_half_z <= p.mhz;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (results_seen != items_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_csrs(input logic signed [31:0] ox, input logic signed [31:0] oy,
                            input logic signed [31:0] oz, input logic [30:0] stp);
      csr_write <= 1'b1;
      csr_index <= aabb_por_pkg::CSR_OFFSET_X;
      csr_data  <= ox;
      @(posedge clock);
      csr_index <= aabb_por_pkg::CSR_OFFSET_Y;
      csr_data  <= oy;
      @(posedge clock);
      csr_index <= aabb_por_pkg::CSR_OFFSET_Z;
      csr_data  <= oz;
      @(posedge clock);
      // top bit is outside the step register and must be ignored
      csr_index <= aabb_por_pkg::CSR_PUSH_STEP;
      csr_data  <= {1'($urandom_range(0, 1)), stp};
      @(posedge clock);
      csr_write <= 1'b0;
      cur_ox = ox;
      cur_oy = oy;
      cur_oz = oz;
      settings++;
   endtask

   task automatic run_phase(input int count, input longint hmax, input int calm_from,
                            input int calm_to, input int hold_at);
      for (int i = 0; i < count; i++) begin
         calm = (i >= calm_from && i < calm_to);
         if (i == hold_at)
            hold_request = 1'b1;
         send_pair(make_pair(hmax));
      end
      calm = 1'b0;
      wait_results();
   endtask

   // receiver: random stalls, plus one long hold-off on request so the block backs up
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 19);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_static_x      = '0;
      req_static_y      = '0;
      req_static_z      = '0;
      req_static_half_x = '0;
      req_static_half_y = '0;
      req_static_half_z = '0;
      req_moving_x      = '0;
      req_moving_y      = '0;
      req_moving_z      = '0;
      req_moving_half_x = '0;
      req_moving_half_y = '0;
      req_moving_half_z = '0;
      rsp_stall         = 1'b0;
      csr_write         = 1'b0;
      csr_index         = aabb_por_pkg::CSR_OFFSET_X;
      csr_data          = '0;
      calm              = 1'b0;
      hold_request      = 1'b0;
      hold_left         = 0;
      items_sent        = 0;
      settings          = 1;
      cur_ox            = '0;
      cur_oy            = '0;
      cur_oz            = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset csr values: zero offsets, step 0.1
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        5 * ONE, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // edges exactly touching count as overlap; one lsb apart does not
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        2 * ONE, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        2 * ONE + 1, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        0, -2 * ONE, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        0, 0, -2 * ONE - 1, HALF_ONE, HALF_ONE, HALF_ONE));
      // deep overlap, many rounds
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        0, 0, 0, 31'h8000, 31'h8000, 31'h8000));
      // +x saturates and stays blocked, -x frees
      send_pair(pair_of(POS_MAX, 0, 0, HALF_ONE, HALF_MAX, HALF_MAX,
                        POS_MAX, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      // x blocked both ways: +z, then -z after saturation
      send_pair(pair_of(0, 0, 0, HALF_MAX, HALF_MAX, HALF_ONE,
                        0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, POS_MAX, HALF_MAX, HALF_MAX, HALF_ONE,
                        0, 0, POS_MAX, HALF_ONE, HALF_ONE, HALF_ONE));
      // only y free: +y, then -y after saturation
      send_pair(pair_of(0, 0, 0, HALF_MAX, HALF_ONE, HALF_MAX,
                        0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, POS_MAX, 0, HALF_MAX, HALF_ONE, HALF_MAX,
                        0, POS_MAX, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(POS_MIN, POS_MIN, POS_MIN, HALF_ONE, HALF_ONE, HALF_ONE,
                        POS_MIN, POS_MIN, POS_MIN, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0,
                        POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
      // full-size boxes: no round limit is enough
      send_pair(pair_of(0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX,
                        0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
      wait_results();

      // zero step: any overlap stays unresolved
      load_csrs(0, 0, 0, 31'd0);
      send_pair(pair_of(ONE, ONE, ONE, HALF_ONE, HALF_ONE, HALF_ONE,
                        ONE, ONE, ONE, HALF_ONE, HALF_ONE, HALF_ONE));
      send_pair(pair_of(0, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE,
                        -5 * ONE, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE));
      wait_results();

      load_csrs(small_offset(), small_offset(), small_offset(), 31'd6554);
      run_phase(400, 8 * 6554, -1, -1, 50);

      load_csrs(POS_MAX, POS_MIN, 0, 31'd1);
      run_phase(300, 8, -1, -1, -1);

      load_csrs($urandom, $urandom, $urandom,
                31'($urandom_range(32'h0800_0000, 32'h7FFF_FFFF)));
      run_phase(350, 64'd536870911, -1, -1, -1);

      mid_step = 31'($urandom_range(1000, 200000));
      load_csrs(small_offset(), small_offset(), small_offset(), mid_step);
      run_phase(350, 6 * longint'(mid_step), 100, 250, -1);

      load_csrs(POS_MIN, POS_MAX, $urandom, 31'h7FFF_FFFF);
      run_phase(300, 64'd536870911, -1, -1, -1);

      repeat (20) @(posedge clock);
      if (expect_depth != 0)
         $error("%0d expected result words never arrived", expect_depth);
      $display("Covered %0d words under %0d csr settings: %0d started overlapped, %0d unresolved",
               results_seen, settings, overlaps_seen, unresolved_seen);
      if (fail_count == 0 && expect_depth == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/aabb_por_pkg.sv
sv/aabb_por_seq.sv
sv/aabb_por_dp.sv
sv/aabb_push_out_resolver.sv
sv/aabb_por_chk.sv
test/aabb_push_checker.sv
test/tb_aabb_push_out_resolver.sv
